/* hdl/sdm_pkg.sv */
package sdm_pkg;

    // Field widths of the item and result transfers
    localparam int CMD_W    = 2;
    localparam int COORD_W  = 32;
    localparam int RATE_W   = 19;
    localparam int SPM_W    = 16;
    localparam int SPEED_W  = 31;

    // Internal widths
    localparam int HALF_W       = 20;
    localparam int DVS_W        = 20;
    localparam int DELTA_W      = COORD_W + 1;
    localparam int PROD_W       = DELTA_W + SPM_W;
    localparam int STEPS_FULL_W = PROD_W + 1 - 16;
    localparam int SPEED_DIV_W  = RATE_W + 16 + 1;

    // Defaults for the top-level parameters
    localparam int SDM_TICKS_PER_SECOND = 1000000;
    localparam int SDM_POSITION_WIDTH   = 32;

    // Register reset value and fixed-point limits
    localparam logic [SPM_W-1:0]   SPM_RESET  = 16'd80;
    localparam logic [HALF_W-1:0]  HALF_MAX   = 20'hF_FFFF;
    localparam logic [31:0]        POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0]        NEG_MAG    = 32'h8000_0000;
    localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(32768);

    // Item command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_RESET = 2'd3
    } sdm_code_t;

    // Operand selection of the shared divider
    typedef enum logic [1:0] {
        DIV_POS,
        DIV_HALF,
        DIV_SPEED
    } sdm_div_op_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE,
        S_HALF_GO,
        S_HALF_WAIT,
        S_POS_GO,
        S_POS_WAIT,
        S_SPD_GO,
        S_SPD_WAIT,
        S_OUT
    } sdm_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic        capture;
        logic        do_tick;
        logic        do_move_zero;
        logic        do_mul;
        logic        do_move;
        logic        do_halt;
        logic        do_clear;
        logic        div_start;
        sdm_div_op_t div_op;
        logic        pos_write;
        logic        half_write;
        logic        spd_write;
        logic        out_load;
    } sdm_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        sdm_code_t code;
        logic      rate_zero;
        logic      tick_rise;
        logic      steps_zero;
        logic      div_busy;
        logic      div_done;
        logic      res_free;
    } sdm_sts_t;

endpackage

/* hdl/sdm_if.sv */
// Item channel: one command per transfer
interface sdm_item_if
    import sdm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] target_mm_q16;
    logic [RATE_W-1:0]         step_rate_hz;

    modport source (output valid, output cmd, output target_mm_q16, output step_rate_hz,
                    input ready);
    modport sink (input valid, input cmd, input target_mm_q16, input step_rate_hz,
                  output ready);
endinterface

// Result channel: one axis snapshot per transfer
interface sdm_result_if
    import sdm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      step_level;
    logic                      dir_level;
    logic                      moving;
    logic signed [COORD_W-1:0] position_steps;
    logic signed [COORD_W-1:0] position_mm_q16;
    logic [SPEED_W-1:0]        speed_mm_q16;
    logic                      status;

    modport source (output valid, output step_level, output dir_level, output moving,
                    output position_steps, output position_mm_q16, output speed_mm_q16,
                    output status, input ready);
    modport sink (input valid, input step_level, input dir_level, input moving,
                  input position_steps, input position_mm_q16, input speed_mm_q16,
                  input status, output ready);
endinterface

/* hdl/sdm_div.sv */
module sdm_div
    import sdm_pkg::*;
#(
    parameter int DIVIDEND_W = SPEED_DIV_W,
    parameter int DIVISOR_W  = DVS_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    assign quo_next = {quo_reg[DIVIDEND_W-2:0], fits};

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // A start always opens a run of iterations.
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not begin iterating after start");

endmodule

/* hdl/sdm_ctrl.sv */
module sdm_ctrl
    import sdm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  logic     cfg_we,
    output sdm_ctl_t ctl,
    input  sdm_sts_t sts
);

    sdm_state_t state_reg;
    sdm_state_t state_next;
    logic       item_open_reg;
    logic       cfg_pend_reg;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_pend_reg)
                    state_next = S_SPD_GO;
                else if (item_valid && !cfg_we)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (sts.code) inside
                    CMD_TICK:             state_next = sts.tick_rise ? S_POS_GO : S_OUT;
                    CMD_MOVE:             state_next = sts.rate_zero ? S_SPD_GO : S_MOVE;
                    CMD_STOP, CMD_RESET:  state_next = S_OUT;
                    default:              state_next = S_OUT;
                endcase
            end
            S_MOVE:      state_next = sts.steps_zero ? S_SPD_GO : S_HALF_GO;
            S_HALF_GO:   state_next = S_HALF_WAIT;
            S_HALF_WAIT: state_next = sts.div_done ? S_SPD_GO : S_HALF_WAIT;
            S_POS_GO:    state_next = S_POS_WAIT;
            S_POS_WAIT:  state_next = sts.div_done ? S_OUT : S_POS_WAIT;
            S_SPD_GO:    state_next = S_SPD_WAIT;
            S_SPD_WAIT:
            begin
                if (sts.div_done)
                    state_next = item_open_reg ? S_OUT : S_IDLE;
            end
            S_OUT:       state_next = sts.res_free ? S_IDLE : S_OUT;
            default:     state_next = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        ctl        = '0;
        ctl.div_op = DIV_POS;
        item_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready  = !cfg_pend_reg && !cfg_we;
                ctl.capture = item_valid && !cfg_pend_reg && !cfg_we;
            end
            S_EXEC:
            begin
                ctl.do_tick      = sts.code == CMD_TICK;
                ctl.do_move_zero = sts.code == CMD_MOVE && sts.rate_zero;
                ctl.do_mul       = sts.code == CMD_MOVE && !sts.rate_zero;
                ctl.do_halt      = sts.code == CMD_STOP || sts.code == CMD_RESET;
                ctl.do_clear     = sts.code == CMD_RESET;
            end
            S_MOVE:
            begin
                ctl.do_move = 1'b1;
            end
            S_HALF_GO:
            begin
                ctl.div_start = 1'b1;
                ctl.div_op    = DIV_HALF;
            end
            S_HALF_WAIT:
            begin
                ctl.div_op     = DIV_HALF;
                ctl.half_write = sts.div_done;
            end
            S_POS_GO:
            begin
                ctl.div_start = 1'b1;
                ctl.div_op    = DIV_POS;
            end
            S_POS_WAIT:
            begin
                ctl.div_op    = DIV_POS;
                ctl.pos_write = sts.div_done;
            end
            S_SPD_GO:
            begin
                ctl.div_start = 1'b1;
                ctl.div_op    = DIV_SPEED;
            end
            S_SPD_WAIT:
            begin
                ctl.div_op    = DIV_SPEED;
                ctl.spd_write = sts.div_done;
            end
            S_OUT:
            begin
                ctl.out_load = sts.res_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // State, open-item and pending speed update flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_open_reg <= 1'b0;
            cfg_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.capture)
                item_open_reg <= 1'b1;
            else if (ctl.out_load)
                item_open_reg <= 1'b0;
            if (cfg_we)
                cfg_pend_reg <= 1'b1;
            else if (ctl.spd_write)
                cfg_pend_reg <= 1'b0;
        end
    end

    // The divider is never restarted in the middle of a run.
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // One result per item: no new item while one is open, no result without one.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |-> !item_open_reg)
        else $error("item taken while the previous one is still open");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> item_open_reg)
        else $error("result loaded with no open item");

endmodule

/* hdl/sdm_datapath.sv */
module sdm_datapath
    import sdm_pkg::*;
#(
    parameter int TICKS_PER_SECOND = SDM_TICKS_PER_SECOND,
    parameter int POSITION_WIDTH   = SDM_POSITION_WIDTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sdm_ctl_t                  ctl,
    output sdm_sts_t                  sts,
    input  logic [CMD_W-1:0]          cmd,
    input  logic signed [COORD_W-1:0] target_mm_q16,
    input  logic [RATE_W-1:0]         step_rate_hz,
    input  logic                      cfg_we,
    input  logic [SPM_W-1:0]          cfg_wdata,
    sdm_result_if.source              result
);

    localparam int PW    = POSITION_WIDTH;
    localparam int DIV_W = (PW + 16 > SPEED_DIV_W) ? PW + 16 : SPEED_DIV_W;

    // Configuration and axis state
    logic [SPM_W-1:0]   spm_reg;
    logic               step_line_reg;
    logic signed [1:0]  dir_reg;
    logic               active_reg;
    logic [PW-1:0]      count_reg;
    logic [31:0]        pos_reg;
    logic [31:0]        done_steps_reg;
    logic [31:0]        need_steps_reg;
    logic [HALF_W-1:0]  half_reg;
    logic [HALF_W-1:0]  tc_reg;
    logic [RATE_W-1:0]  rate_held_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               status_reg;
    logic               res_valid_reg;

    // Item and intermediate registers
    logic [CMD_W-1:0]   cmd_reg;
    logic [COORD_W-1:0] target_reg;
    logic [RATE_W-1:0]  rate_in_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               prod_neg_reg;

    // Result registers
    logic               res_step_reg;
    logic               res_dir_reg;
    logic               res_moving_reg;
    logic [31:0]        res_steps_reg;
    logic [31:0]        res_pos_reg;
    logic [SPEED_W-1:0] res_speed_reg;
    logic               res_status_reg;

    // Combinational values
    logic [HALF_W-1:0]       tc_inc;
    logic                    tick_hit;
    logic [31:0]             done_inc;
    logic [PW-1:0]           dir_ext;
    logic [DELTA_W-1:0]      delta;
    logic [DELTA_W-1:0]      dmag;
    logic [PROD_W-1:0]       prod_next;
    logic [PROD_W:0]         rounded;
    logic [STEPS_FULL_W-1:0] steps_full;
    logic [31:0]             steps_sat;
    logic                    steps_zero;
    logic                    cnt_neg;
    logic [PW-1:0]           cnt_mag;
    logic [SPM_W-1:0]        pos_dvs;
    logic [DIV_W-1:0]        div_dividend;
    logic [DVS_W-1:0]        div_divisor;
    logic                    div_busy;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quo;
    logic [31:0]             pos_mag;
    logic [31:0]             pos_result;
    logic [HALF_W-1:0]       half_result;
    logic [SPEED_W-1:0]      speed_result;
    logic [31:0]             steps_out;

    // Tick counter and step edge detection
    assign tc_inc   = tc_reg + 1'b1;
    assign tick_hit = tc_inc >= half_reg;
    assign done_inc = done_steps_reg + 1'b1;
    assign dir_ext  = {{(PW - 2){dir_reg[1]}}, dir_reg};

    // Distance to target, scaled by steps per millimetre
    assign delta     = {target_reg[COORD_W-1], target_reg} - {pos_reg[31], pos_reg};
    assign dmag      = delta[DELTA_W-1] ? (~delta + 1'b1) : delta;
    assign prod_next = PROD_W'(dmag) * PROD_W'(spm_reg);

    // Round the Q16 product to whole steps and saturate to 32 bits
    assign rounded    = {1'b0, prod_reg} + ROUND_HALF;
    assign steps_full = rounded[PROD_W:16];
    assign steps_sat  = (|steps_full[STEPS_FULL_W-1:32]) ? '1 : steps_full[31:0];
    assign steps_zero = steps_full == '0;

    // Step count magnitude for the position conversion
    assign cnt_neg = count_reg[PW-1];
    assign cnt_mag = cnt_neg ? (~count_reg + 1'b1) : count_reg;
    assign pos_dvs = (spm_reg == '0) ? SPM_W'(1) : spm_reg;

    // Divider operand selection
    always_comb
    begin
        case (ctl.div_op)
            DIV_POS:
            begin
                div_dividend = DIV_W'({cnt_mag, 16'h0}) + DIV_W'(pos_dvs >> 1);
                div_divisor  = DVS_W'(pos_dvs);
            end
            DIV_HALF:
            begin
                div_dividend = DIV_W'(TICKS_PER_SECOND);
                div_divisor  = {rate_in_reg, 1'b0};
            end
            DIV_SPEED:
            begin
                div_dividend = DIV_W'({rate_held_reg, 16'h0}) + DIV_W'(spm_reg >> 1);
                div_divisor  = DVS_W'(spm_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    sdm_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Saturate and sign the divider results
    always_comb
    begin
        if (cnt_neg)
        begin
            pos_mag    = (div_quo > DIV_W'(NEG_MAG)) ? NEG_MAG : div_quo[31:0];
            pos_result = ~pos_mag + 1'b1;
        end
        else
        begin
            pos_mag    = (div_quo > DIV_W'(POS_MAX)) ? POS_MAX : div_quo[31:0];
            pos_result = pos_mag;
        end

        if (div_quo == '0)
            half_result = HALF_W'(1);
        else if (div_quo > DIV_W'(HALF_MAX))
            half_result = HALF_MAX;
        else
            half_result = div_quo[HALF_W-1:0];

        if (spm_reg == '0)
            speed_result = '0;
        else if (div_quo > DIV_W'(POS_MAX))
            speed_result = '1;
        else
            speed_result = div_quo[SPEED_W-1:0];
    end

    // Low 32 bits of the step count for the result
    generate
        if (PW >= 32)
        begin : g_steps_wide
            assign steps_out = count_reg[31:0];
        end
        else
        begin : g_steps_narrow
            assign steps_out = {{(32 - PW){1'b0}}, count_reg};
        end
    endgenerate

    // Axis state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spm_reg        <= SPM_RESET;
            step_line_reg  <= 1'b0;
            dir_reg        <= '0;
            active_reg     <= 1'b0;
            count_reg      <= '0;
            pos_reg        <= '0;
            done_steps_reg <= '0;
            need_steps_reg <= '0;
            half_reg       <= HALF_W'(1);
            tc_reg         <= '0;
            rate_held_reg  <= '0;
            speed_reg      <= '0;
            status_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                spm_reg <= cfg_wdata;

            if (ctl.capture)
                status_reg <= 1'b0;

            // Tick: count towards the half period, toggle, and step on a rising edge
            if (ctl.do_tick && active_reg)
            begin
                tc_reg <= tick_hit ? '0 : tc_inc;
                if (tick_hit)
                begin
                    step_line_reg <= !step_line_reg;
                    if (!step_line_reg)
                    begin
                        count_reg      <= count_reg + dir_ext;
                        done_steps_reg <= done_inc;
                        if (done_inc >= need_steps_reg)
                            active_reg <= 1'b0;
                    end
                end
            end

            // Move rejected for a zero rate
            if (ctl.do_move_zero)
            begin
                rate_held_reg <= '0;
                status_reg    <= 1'b1;
            end

            // Move accepted: set up the new motion
            if (ctl.do_move)
            begin
                rate_held_reg <= rate_in_reg;
                active_reg    <= 1'b0;
                if (steps_zero)
                begin
                    dir_reg <= '0;
                end
                else
                begin
                    dir_reg        <= prod_neg_reg ? 2'sb11 : 2'sb01;
                    need_steps_reg <= steps_sat;
                    done_steps_reg <= '0;
                    tc_reg         <= '0;
                    active_reg     <= 1'b1;
                end
            end

            // Stop, and reset which also zeroes the position
            if (ctl.do_halt)
            begin
                active_reg     <= 1'b0;
                dir_reg        <= '0;
                done_steps_reg <= '0;
                need_steps_reg <= '0;
                tc_reg         <= '0;
                step_line_reg  <= 1'b0;
                if (ctl.do_clear)
                begin
                    count_reg <= '0;
                    pos_reg   <= '0;
                end
            end

            if (ctl.pos_write)
                pos_reg <= pos_result;
            if (ctl.half_write)
                half_reg <= half_result;
            if (ctl.spd_write)
                speed_reg <= speed_result;

            // Result register occupancy
            if (ctl.out_load)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Item capture, product and result snapshot
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg     <= cmd;
            target_reg  <= target_mm_q16;
            rate_in_reg <= step_rate_hz;
        end
        if (ctl.do_mul)
        begin
            prod_reg     <= prod_next;
            prod_neg_reg <= delta[DELTA_W-1];
        end
        if (ctl.out_load)
        begin
            res_step_reg   <= step_line_reg;
            res_dir_reg    <= dir_reg == 2'sb01;
            res_moving_reg <= active_reg;
            res_steps_reg  <= steps_out;
            res_pos_reg    <= pos_reg;
            res_speed_reg  <= speed_reg;
            res_status_reg <= status_reg;
        end
    end

    // Status to the controller
    assign sts.code       = sdm_code_t'(cmd_reg);
    assign sts.rate_zero  = rate_in_reg == '0;
    assign sts.tick_rise  = active_reg && tick_hit && !step_line_reg;
    assign sts.steps_zero = steps_zero;
    assign sts.div_busy   = div_busy;
    assign sts.div_done   = div_done;
    assign sts.res_free   = !res_valid_reg || result.ready;

    // Result channel
    assign result.valid           = res_valid_reg;
    assign result.step_level      = res_step_reg;
    assign result.dir_level       = res_dir_reg;
    assign result.moving          = res_moving_reg;
    assign result.position_steps  = res_steps_reg;
    assign result.position_mm_q16 = res_pos_reg;
    assign result.speed_mm_q16    = res_speed_reg;
    assign result.status          = res_status_reg;

    // A running move always has a direction.
    a_active_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> dir_reg != 2'sb00)
        else $error("move active with no direction");

endmodule

/* hdl/step_dir_move_generator.sv */
// Channel   | Role   | Handshake          | Payload
// item      | sink   | valid / ready      | cmd, target_mm_q16, step_rate_hz
// result    | source | valid / ready      | step_level, dir_level, moving, position_steps,
//           |        |                    | position_mm_q16, speed_mm_q16, status
// cfg       | sink   | cfg_we, no stall   | cfg_wdata (steps per millimetre)
//
// Stop, reset and ticks without a step edge pass from transfer to result without the divider.
// A tick that raises the step line recomputes the position in the shared divider, and a move
// with steps uses it twice (half period, then speed): the divider yields one bit per cycle.
// A configuration write recomputes the speed in the divider; no item is taken while it is pending.
// rst_n clears all axis state at once; the steps-per-millimetre register returns to 80.
// A waiting result sits in its own register, so the next item is taken meanwhile.
module step_dir_move_generator
    import sdm_pkg::*;
#(
    parameter int TICKS_PER_SECOND = SDM_TICKS_PER_SECOND,
    parameter int POSITION_WIDTH   = SDM_POSITION_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    sdm_item_if.sink         item,
    sdm_result_if.source     result,
    input  logic             cfg_we,
    input  logic [SPM_W-1:0] cfg_wdata
);

    sdm_ctl_t ctl;
    sdm_sts_t sts;
    logic     item_ready;

    assign item.ready = item_ready;

    // Sequencer for each item
    sdm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .cfg_we     (cfg_we),
        .ctl        (ctl),
        .sts        (sts)
    );

    // Axis state, arithmetic and result register
    sdm_datapath #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .POSITION_WIDTH   (POSITION_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .cmd           (item.cmd),
        .target_mm_q16 (item.target_mm_q16),
        .step_rate_hz  (item.step_rate_hz),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result        (result)
    );

endmodule
